// ----- sv/psbs_pkg.sv -----
// shared types and constants for the permutation swap sorter
// no dependencies; used by psbs_result and permutation_sort_by_swaps
package psbs_pkg;

    localparam int MAX_N_DEF = 64;
    localparam int VALUE_W   = 7;
    localparam int POS_W     = 7;
    localparam int TOTAL_W   = 6;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last_item;
    } psbs_in_t;

    typedef struct packed {
        logic [POS_W-1:0]   first_position;
        logic [POS_W-1:0]   second_position;
        logic               pair_valid;
        logic [TOTAL_W-1:0] total_swaps;
        logic               bad_input;
        logic               last_result;
    } psbs_out_t;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_SWAP,
        EMIT_FINISH,
        EMIT_BAD
    } psbs_emit_op_t;

    typedef struct packed {
        psbs_emit_op_t    op;
        logic [POS_W-1:0] first;
        logic [POS_W-1:0] second;
    } psbs_emit_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_CHK_RD,
        ST_CHK_VAL,
        ST_CHK_SEEN,
        ST_PT_RD,
        ST_PT_CMP,
        ST_PT_SCAN,
        ST_CF_RD,
        ST_CF_CMP,
        ST_CF_SWAP,
        ST_EMIT,
        ST_FINISH,
        ST_BAD
    } psbs_state_t;

endpackage

// ----- sv/psbs_ram.sv -----
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module psbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/psbs_result.sv -----
// result stage: holds the latest swap back until it is known whether it is the last,
// then drives the output register; depends on psbs_pkg
module psbs_result (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  psbs_pkg::psbs_emit_t  emit,
    output logic                  emit_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output psbs_pkg::psbs_out_t   m_payload
);

    localparam int TOTAL_W = psbs_pkg::TOTAL_W;

    logic                m_valid_reg, m_valid_next;
    psbs_pkg::psbs_out_t out_reg, out_next;
    logic                hold_vld_reg, hold_vld_next;
    psbs_pkg::psbs_out_t hold_reg, hold_next;
    logic                out_free;
    logic [TOTAL_W-1:0]  count;

    assign out_free = !m_valid_reg || m_ready;
    // running swap count lives in the held result
    assign count    = hold_vld_reg ? hold_reg.total_swaps : '0;

    always_comb begin
        case (emit.op)
            psbs_pkg::EMIT_SWAP:   emit_ready = !hold_vld_reg || out_free;
            psbs_pkg::EMIT_FINISH: emit_ready = out_free;
            psbs_pkg::EMIT_BAD:    emit_ready = out_free;
            default:               emit_ready = 1'b0;
        endcase
    end

    always_comb begin
        m_valid_next  = m_valid_reg;
        out_next      = out_reg;
        hold_vld_next = hold_vld_reg;
        hold_next     = hold_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (emit_ready) begin
            case (emit.op)
                psbs_pkg::EMIT_SWAP: begin
                    if (hold_vld_reg) begin
                        out_next     = hold_reg;
                        m_valid_next = 1'b1;
                    end
                    hold_vld_next             = 1'b1;
                    hold_next.first_position  = emit.first;
                    hold_next.second_position = emit.second;
                    hold_next.pair_valid      = 1'b1;
                    hold_next.total_swaps     = count + TOTAL_W'(1);
                    hold_next.bad_input       = 1'b0;
                    hold_next.last_result     = 1'b0;
                end
                psbs_pkg::EMIT_FINISH: begin
                    m_valid_next  = 1'b1;
                    hold_vld_next = 1'b0;
                    if (hold_vld_reg) begin
                        out_next             = hold_reg;
                        out_next.last_result = 1'b1;
                    end else begin
                        out_next             = '0;
                        out_next.last_result = 1'b1;
                    end
                end
                psbs_pkg::EMIT_BAD: begin
                    m_valid_next         = 1'b1;
                    hold_vld_next        = 1'b0;
                    out_next             = '0;
                    out_next.bad_input   = 1'b1;
                    out_next.last_result = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            hold_vld_reg <= 1'b0;
        end else begin
            m_valid_reg  <= m_valid_next;
            hold_vld_reg <= hold_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        hold_reg <= hold_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

    a_bad_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_reg.bad_input) |->
            (!out_reg.pair_valid && out_reg.last_result && out_reg.total_swaps == '0))
        else $error("error result carries more than the flag");

    a_hold_pushed: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit.op == psbs_pkg::EMIT_SWAP && emit_ready && hold_vld_reg) |=>
            (m_valid_reg && out_reg.pair_valid && !out_reg.last_result))
        else $error("held swap not moved to output");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit.op == psbs_pkg::EMIT_SWAP && emit_ready && hold_vld_reg) |=>
            (hold_reg.total_swaps == TOTAL_W'($past(hold_reg.total_swaps) + TOTAL_W'(1))))
        else $error("swap count did not step by one");

endmodule

// ----- sv/permutation_sort_by_swaps.sv -----
// top level of the permutation swap sorter: sequencer, store and mark memories
// depends on psbs_pkg, psbs_ram and psbs_result
//
// channel   dir  handshake            payload
// s_        in   s_valid / s_ready    psbs_in_t   (value, last_item)
// m_        out  m_valid / m_ready    psbs_out_t  (swap pair, count, flags)
// cfg_      in   cfg_valid/cfg_ready  cfg_data    (place_from_top)
//
// loading: one request a cycle, s_ready high while the sequencer sits in load
// check: per element a store read, a mark read and a mark write, after the last request
// place-from-top: a read and a compare per position, plus a pipelined scan and an emit
//   for each swap; cycle-follow: read and compare per position, plus emit and swap per swap
// reset: synchronous; the store needs no clearing pass, the marks for positions
//   1..n are cleared as the values are loaded
// stalls: m_ready low halts the sequencer when a new swap meets a full output
//   register and a full hold stage, or when the final or error result meets a
//   full output register
module permutation_sort_by_swaps #(
    parameter int MAX_N = psbs_pkg::MAX_N_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  psbs_pkg::psbs_in_t   s_payload,
    output logic                 m_valid,
    input  logic                 m_ready,
    output psbs_pkg::psbs_out_t  m_payload,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data
);

    localparam int VALUE_W = psbs_pkg::VALUE_W;
    localparam int POS_W   = psbs_pkg::POS_W;
    // position counters must hold n+1 and the overflow mark MAX_N+1
    localparam int PW      = $clog2(MAX_N + 2);
    localparam int AW      = $clog2(MAX_N);
    // common width for comparing stored values with positions
    localparam int CW      = (PW > VALUE_W) ? PW : VALUE_W;
    localparam logic [PW-1:0] N_MAX  = PW'(MAX_N);
    localparam logic [PW-1:0] N_OVER = PW'(MAX_N + 1);
    localparam logic [PW-1:0] ONE_P  = PW'(1);

    // configuration register
    logic pft_reg;

    // sequencer state
    psbs_pkg::psbs_state_t state_reg, state_next;
    logic [PW-1:0]         load_cnt_reg, load_cnt_next;
    logic [PW-1:0]         i_reg, i_next;
    logic [PW-1:0]         j_reg, j_next;
    logic                  look_vld_reg, look_vld_next;
    logic [PW-1:0]         look_pos_reg, look_pos_next;
    logic [VALUE_W-1:0]    cur_reg, cur_next;
    logic [POS_W-1:0]      pa_reg, pa_next;
    logic [POS_W-1:0]      pb_reg, pb_next;

    // strategy only changes while the sequencer sits in load
    assign cfg_ready = (state_reg == psbs_pkg::ST_LOAD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pft_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            pft_reg <= cfg_data;
        end
    end

    // store and mark memory ports
    logic               perm_we, perm_re;
    logic [AW-1:0]      perm_waddr, perm_raddr;
    logic [VALUE_W-1:0] perm_wdata, perm_rdata;
    logic               seen_we, seen_re;
    logic [AW-1:0]      seen_waddr, seen_raddr;
    logic               seen_wdata, seen_rdata;

    psbs_pkg::psbs_emit_t emit;
    logic                 emit_ready;

    logic rd_is_i;
    logic i_is_n;

    assign rd_is_i = (CW'(perm_rdata) == CW'(i_reg));
    assign i_is_n  = (i_reg == load_cnt_reg);

    always_comb begin
        state_next    = state_reg;
        load_cnt_next = load_cnt_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        look_vld_next = look_vld_reg;
        look_pos_next = look_pos_reg;
        cur_next      = cur_reg;
        pa_next       = pa_reg;
        pb_next       = pb_reg;
        perm_we       = 1'b0;
        perm_waddr    = '0;
        perm_wdata    = '0;
        perm_re       = 1'b0;
        perm_raddr    = '0;
        seen_we       = 1'b0;
        seen_waddr    = '0;
        seen_wdata    = 1'b0;
        seen_re       = 1'b0;
        seen_raddr    = '0;
        emit          = '{op: psbs_pkg::EMIT_NONE, first: '0, second: '0};
        s_ready       = 1'b0;

        case (state_reg)
            psbs_pkg::ST_LOAD: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (load_cnt_reg < N_MAX) begin
                        // store the value and clear the mark of the same position
                        perm_we       = 1'b1;
                        perm_waddr    = AW'(load_cnt_reg);
                        perm_wdata    = s_payload.value;
                        seen_we       = 1'b1;
                        seen_waddr    = AW'(load_cnt_reg);
                        seen_wdata    = 1'b0;
                        load_cnt_next = load_cnt_reg + ONE_P;
                    end else begin
                        load_cnt_next = N_OVER;
                    end
                    if (s_payload.last_item) begin
                        if (load_cnt_reg >= N_MAX) begin
                            state_next = psbs_pkg::ST_BAD;
                        end else begin
                            i_next     = ONE_P;
                            state_next = psbs_pkg::ST_CHK_RD;
                        end
                    end
                end
            end
            psbs_pkg::ST_CHK_RD: begin
                perm_re    = 1'b1;
                perm_raddr = AW'(i_reg - ONE_P);
                state_next = psbs_pkg::ST_CHK_VAL;
            end
            psbs_pkg::ST_CHK_VAL: begin
                if (perm_rdata == '0 || CW'(perm_rdata) > CW'(load_cnt_reg)) begin
                    state_next = psbs_pkg::ST_BAD;
                end else begin
                    seen_re    = 1'b1;
                    seen_raddr = AW'(CW'(perm_rdata) - CW'(1));
                    cur_next   = perm_rdata;
                    state_next = psbs_pkg::ST_CHK_SEEN;
                end
            end
            psbs_pkg::ST_CHK_SEEN: begin
                if (seen_rdata) begin
                    state_next = psbs_pkg::ST_BAD;
                end else begin
                    seen_we    = 1'b1;
                    seen_waddr = AW'(CW'(cur_reg) - CW'(1));
                    seen_wdata = 1'b1;
                    if (i_is_n) begin
                        if (pft_reg) begin
                            i_next     = load_cnt_reg;
                            state_next = psbs_pkg::ST_PT_RD;
                        end else begin
                            i_next     = ONE_P;
                            state_next = psbs_pkg::ST_CF_RD;
                        end
                    end else begin
                        i_next     = i_reg + ONE_P;
                        state_next = psbs_pkg::ST_CHK_RD;
                    end
                end
            end
            psbs_pkg::ST_PT_RD: begin
                perm_re    = 1'b1;
                perm_raddr = AW'(i_reg - ONE_P);
                state_next = psbs_pkg::ST_PT_CMP;
            end
            psbs_pkg::ST_PT_CMP: begin
                cur_next = perm_rdata;
                if (rd_is_i) begin
                    if (i_reg == ONE_P) begin
                        state_next = psbs_pkg::ST_FINISH;
                    end else begin
                        i_next     = i_reg - ONE_P;
                        state_next = psbs_pkg::ST_PT_RD;
                    end
                end else begin
                    j_next        = ONE_P;
                    look_vld_next = 1'b0;
                    state_next    = psbs_pkg::ST_PT_SCAN;
                end
            end
            psbs_pkg::ST_PT_SCAN: begin
                if (look_vld_reg && rd_is_i) begin
                    // only the far side needs writing: position i is never read again
                    perm_we       = 1'b1;
                    perm_waddr    = AW'(look_pos_reg - ONE_P);
                    perm_wdata    = cur_reg;
                    pa_next       = POS_W'(i_reg);
                    pb_next       = POS_W'(look_pos_reg);
                    look_vld_next = 1'b0;
                    state_next    = psbs_pkg::ST_EMIT;
                end else if (j_reg <= load_cnt_reg) begin
                    perm_re       = 1'b1;
                    perm_raddr    = AW'(j_reg - ONE_P);
                    look_vld_next = 1'b1;
                    look_pos_next = j_reg;
                    j_next        = j_reg + ONE_P;
                end else begin
                    look_vld_next = 1'b0;
                end
            end
            psbs_pkg::ST_EMIT: begin
                emit = '{op: psbs_pkg::EMIT_SWAP, first: pa_reg, second: pb_reg};
                if (emit_ready) begin
                    if (pft_reg) begin
                        if (i_reg == ONE_P) begin
                            state_next = psbs_pkg::ST_FINISH;
                        end else begin
                            i_next     = i_reg - ONE_P;
                            state_next = psbs_pkg::ST_PT_RD;
                        end
                    end else begin
                        state_next = psbs_pkg::ST_CF_SWAP;
                    end
                end
            end
            psbs_pkg::ST_CF_RD: begin
                perm_re    = 1'b1;
                perm_raddr = AW'(i_reg - ONE_P);
                state_next = psbs_pkg::ST_CF_CMP;
            end
            psbs_pkg::ST_CF_CMP, psbs_pkg::ST_CF_SWAP: begin
                // read data is a[i], first from the store, then the value fetched from a[c]
                if (state_reg == psbs_pkg::ST_CF_SWAP) begin
                    perm_we    = 1'b1;
                    perm_waddr = AW'(CW'(cur_reg) - CW'(1));
                    perm_wdata = cur_reg;
                end
                if (rd_is_i) begin
                    if (i_is_n) begin
                        state_next = psbs_pkg::ST_FINISH;
                    end else begin
                        i_next     = i_reg + ONE_P;
                        state_next = psbs_pkg::ST_CF_RD;
                    end
                end else begin
                    pa_next    = POS_W'(i_reg);
                    pb_next    = POS_W'(perm_rdata);
                    cur_next   = perm_rdata;
                    perm_re    = 1'b1;
                    perm_raddr = AW'(CW'(perm_rdata) - CW'(1));
                    state_next = psbs_pkg::ST_EMIT;
                end
            end
            psbs_pkg::ST_FINISH: begin
                emit = '{op: psbs_pkg::EMIT_FINISH, first: '0, second: '0};
                if (emit_ready) begin
                    load_cnt_next = '0;
                    state_next    = psbs_pkg::ST_LOAD;
                end
            end
            psbs_pkg::ST_BAD: begin
                emit = '{op: psbs_pkg::EMIT_BAD, first: '0, second: '0};
                if (emit_ready) begin
                    load_cnt_next = '0;
                    state_next    = psbs_pkg::ST_LOAD;
                end
            end
            default: begin
                state_next = psbs_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= psbs_pkg::ST_LOAD;
            load_cnt_reg <= '0;
            look_vld_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            look_vld_reg <= look_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg        <= i_next;
        j_reg        <= j_next;
        look_pos_reg <= look_pos_next;
        cur_reg      <= cur_next;
        pa_reg       <= pa_next;
        pb_reg       <= pb_next;
    end

    // permutation store, positions 1..MAX_N at addresses 0..MAX_N-1
    psbs_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_N)
    ) u_perm_ram (
        .aclk  (aclk),
        .we    (perm_we),
        .waddr (perm_waddr),
        .wdata (perm_wdata),
        .re    (perm_re),
        .raddr (perm_raddr),
        .rdata (perm_rdata)
    );

    // seen marks, indexed by value
    psbs_ram #(
        .WIDTH (1),
        .DEPTH (MAX_N)
    ) u_seen_ram (
        .aclk  (aclk),
        .we    (seen_we),
        .waddr (seen_waddr),
        .wdata (seen_wdata),
        .re    (seen_re),
        .raddr (seen_raddr),
        .rdata (seen_rdata)
    );

    psbs_result u_result (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .emit       (emit),
        .emit_ready (emit_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_payload  (m_payload)
    );

    a_last_leaves_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_payload.last_item) |=> (state_reg != psbs_pkg::ST_LOAD))
        else $error("last request did not start the run");

    a_scan_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == psbs_pkg::ST_PT_SCAN) |-> (i_reg >= ONE_P && i_reg <= load_cnt_reg))
        else $error("scan target outside 1..n");

    a_mark_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (seen_we && seen_wdata) |->
            (cur_reg != '0 && CW'(cur_reg) <= CW'(load_cnt_reg)))
        else $error("mark set for a value outside 1..n");

    a_pair_distinct: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == psbs_pkg::ST_EMIT) |-> (pa_reg != pb_reg && pa_reg != '0))
        else $error("swap pair not two distinct positions");

endmodule
